/* rtl/ccio_pkg.sv */
// package: shared types and constants of the cpu i/o register block
package ccio_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [16:0] PTR_MASK  = 17'h1ffff;
  localparam logic [15:0] PORT_DATA = 16'h2180;
  localparam logic [15:0] CHAN_BASE = 16'h4300;

  localparam logic [15:0] A_PTR_LO  = 16'h2181;
  localparam logic [15:0] A_PTR_MID = 16'h2182;
  localparam logic [15:0] A_PTR_HI  = 16'h2183;
  localparam logic [15:0] A_IO_PORT = 16'h4201;
  localparam logic [15:0] A_MUL_L   = 16'h4202;
  localparam logic [15:0] A_MUL_R   = 16'h4203;
  localparam logic [15:0] A_DVD_LO  = 16'h4204;
  localparam logic [15:0] A_DVD_HI  = 16'h4205;
  localparam logic [15:0] A_DIVISOR = 16'h4206;
  localparam logic [15:0] A_HT_LO   = 16'h4207;
  localparam logic [15:0] A_HT_HI   = 16'h4208;
  localparam logic [15:0] A_VT_LO   = 16'h4209;
  localparam logic [15:0] A_VT_HI   = 16'h420a;
  localparam logic [15:0] A_DMA_EN  = 16'h420b;
  localparam logic [15:0] A_HDMA_EN = 16'h420c;
  localparam logic [15:0] A_IO_RD   = 16'h4213;
  localparam logic [15:0] A_QUO_LO  = 16'h4214;
  localparam logic [15:0] A_QUO_HI  = 16'h4215;
  localparam logic [15:0] A_PR_LO   = 16'h4216;
  localparam logic [15:0] A_PR_HI   = 16'h4217;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam int DIV_STEPS = 16;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic exec;
    logic div_start;
  } ccio_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } ccio_sts_t;

endpackage

/* rtl/ccio_datapath.sv */
// datapath: register file, pointer, multiplier and serial divider
module ccio_datapath
  import ccio_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ccio_cmd_t   cmd,
  output ccio_sts_t   sts,
  input  logic        opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  open_bus,
  output logic [7:0]  read_data,
  output logic [1:0]  ram_request,
  output logic [16:0] ram_address,
  output logic [7:0]  ram_data,
  output logic        dma_start,
  output logic        counter_latch
);

  logic [16:0] ram_pointer_r;
  logic [7:0]  mul_left_r, mul_right_r, divisor_r, io_port_r;
  logic [15:0] dividend_r, quotient_r, prod_rem_r;
  logic [8:0]  h_target_r, v_target_r;
  logic [7:0]  dma_mask_r, hdma_mask_r;
  logic [7:0]  ch_ctrl_r [CHANNELS], ch_dest_r [CHANNELS], ch_sbank_r [CHANNELS];
  logic [7:0]  ch_ibank_r [CHANNELS], ch_lines_r [CHANNELS], ch_spare_r [CHANNELS];
  logic [15:0] ch_src_r [CHANNELS], ch_size_r [CHANNELS], ch_tbl_r [CHANNELS];

  logic [15:0] dq_r;
  logic [8:0]  drem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic        dbusy_r;

  logic [2:0]  c3;
  logic [CH_W-1:0] ch;
  logic        chan_hit;
  logic [3:0]  reg_sel;
  logic [7:0]  chan_rd;
  logic [8:0]  trial;
  logic [9:0]  diff;

  assign c3 = address[6:4];
  assign ch = CH_W'(c3);
  assign chan_hit = ((address & 16'hff80) == CHAN_BASE) && ({29'd0, c3} < CHANNELS);
  assign reg_sel = address[3:0];
  assign sts.needs_div = opcode && (address == A_DIVISOR) && (write_data != 8'd0);
  assign sts.div_done = dbusy_r && (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  assign trial = {drem_r[7:0], dq_r[15]};
  assign diff = {1'b0, trial} - {2'b00, divisor_r};

  always_comb begin
    unique case (reg_sel)
      4'h0: chan_rd = ch_ctrl_r[ch];
      4'h1: chan_rd = ch_dest_r[ch];
      4'h2: chan_rd = ch_src_r[ch][7:0];
      4'h3: chan_rd = ch_src_r[ch][15:8];
      4'h4: chan_rd = ch_sbank_r[ch];
      4'h5: chan_rd = ch_size_r[ch][7:0];
      4'h6: chan_rd = ch_size_r[ch][15:8];
      4'h7: chan_rd = ch_ibank_r[ch];
      4'h8: chan_rd = ch_tbl_r[ch][7:0];
      4'h9: chan_rd = ch_tbl_r[ch][15:8];
      4'ha: chan_rd = ch_lines_r[ch];
      4'hb, 4'hf: chan_rd = ch_spare_r[ch];
      default: chan_rd = open_bus;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_pointer_r <= '0; mul_left_r <= '0; mul_right_r <= '0; divisor_r <= '0;
      io_port_r <= '0; dividend_r <= '0; quotient_r <= '0; prod_rem_r <= '0;
      h_target_r <= '0; v_target_r <= '0; dma_mask_r <= '0; hdma_mask_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ch_ctrl_r[i] <= '0; ch_dest_r[i] <= '0; ch_sbank_r[i] <= '0;
        ch_ibank_r[i] <= '0; ch_lines_r[i] <= '0; ch_spare_r[i] <= '0;
        ch_src_r[i] <= '0; ch_size_r[i] <= '0; ch_tbl_r[i] <= '0;
      end
      dbusy_r <= 1'b0; dcnt_r <= '0;
      read_data <= '0; ram_request <= REQ_NONE; ram_address <= '0; ram_data <= '0;
      dma_start <= 1'b0; counter_latch <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r <= '0;
        dq_r <= dividend_r;
        drem_r <= '0;
      end else if (dbusy_r) begin
        if (!diff[9]) begin
          drem_r <= diff[8:0];
          dq_r <= {dq_r[14:0], 1'b1};
        end else begin
          drem_r <= trial;
          dq_r <= {dq_r[14:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (sts.div_done) begin
          dbusy_r <= 1'b0;
          quotient_r <= {dq_r[14:0], ~diff[9]};
          prod_rem_r <= diff[9] ? {7'd0, trial} : {7'd0, diff[8:0]};
        end
      end
      if (cmd.exec) begin
        read_data <= '0; ram_request <= REQ_NONE; ram_address <= '0; ram_data <= '0;
        dma_start <= 1'b0; counter_latch <= 1'b0;
        if (address == PORT_DATA) begin
          ram_request <= opcode ? REQ_WRITE : REQ_READ;
          ram_address <= ram_pointer_r;
          ram_data <= opcode ? write_data : 8'd0;
          ram_pointer_r <= (ram_pointer_r + 17'd1) & PTR_MASK;
        end else if (!opcode) begin
          priority if (address == A_IO_RD) read_data <= io_port_r;
          else if (address == A_QUO_LO) read_data <= quotient_r[7:0];
          else if (address == A_QUO_HI) read_data <= quotient_r[15:8];
          else if (address == A_PR_LO) read_data <= prod_rem_r[7:0];
          else if (address == A_PR_HI) read_data <= prod_rem_r[15:8];
          else if (chan_hit) read_data <= chan_rd;
          else read_data <= open_bus;
        end else begin
          priority case (address)
            A_PTR_LO:  ram_pointer_r[7:0] <= write_data;
            A_PTR_MID: ram_pointer_r[15:8] <= write_data;
            A_PTR_HI:  ram_pointer_r[16] <= write_data[0];
            A_IO_PORT: begin
              counter_latch <= io_port_r[7] && !write_data[7];
              io_port_r <= write_data;
            end
            A_MUL_L: mul_left_r <= write_data;
            A_MUL_R: begin
              mul_right_r <= write_data;
              prod_rem_r <= mul_left_r * write_data;
            end
            A_DVD_LO: dividend_r[7:0] <= write_data;
            A_DVD_HI: dividend_r[15:8] <= write_data;
            A_DIVISOR: begin
              divisor_r <= write_data;
              if (write_data == 8'd0) begin
                quotient_r <= 16'hffff;
                prod_rem_r <= dividend_r;
              end
            end
            A_HT_LO: h_target_r[7:0] <= write_data;
            A_HT_HI: h_target_r[8] <= write_data[0];
            A_VT_LO: v_target_r[7:0] <= write_data;
            A_VT_HI: v_target_r[8] <= write_data[0];
            A_DMA_EN: begin
              dma_mask_r <= write_data;
              dma_start <= write_data != 8'd0;
            end
            A_HDMA_EN: hdma_mask_r <= write_data;
            default: begin
              if (chan_hit) begin
                unique case (reg_sel)
                  4'h0: ch_ctrl_r[ch] <= write_data;
                  4'h1: ch_dest_r[ch] <= write_data;
                  4'h2: ch_src_r[ch][7:0] <= write_data;
                  4'h3: ch_src_r[ch][15:8] <= write_data;
                  4'h4: ch_sbank_r[ch] <= write_data;
                  4'h5: ch_size_r[ch][7:0] <= write_data;
                  4'h6: ch_size_r[ch][15:8] <= write_data;
                  4'h7: ch_ibank_r[ch] <= write_data;
                  4'h8: ch_tbl_r[ch][7:0] <= write_data;
                  4'h9: ch_tbl_r[ch][15:8] <= write_data;
                  4'ha: ch_lines_r[ch] <= write_data;
                  4'hb, 4'hf: ch_spare_r[ch] <= write_data;
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
    end
  end

endmodule

/* rtl/ccio_ctrl.sv */
// controller: accept, divide wait and output handshake
module ccio_ctrl
  import ccio_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ccio_sts_t sts,
  output ccio_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
  state_t state_r;

  logic take;
  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && !in_stall;
  assign cmd.exec = take;
  assign cmd.div_start = take && sts.needs_div;
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (take) state_r <= sts.needs_div ? S_DIV : S_OUT;
        S_DIV:  if (sts.div_done) state_r <= S_OUT;
        S_OUT:  if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/console_cpu_io_register_block.sv */
// top level: cpu i/o register block
// One bus access per word. The result is offered the cycle after the word is accepted or, for a
// write of a nonzero byte to the divisor register, once the one-bit-per-cycle restoring divider
// has finished. The next word is accepted the cycle after the result is taken. No pass after
// reset is needed.
module console_cpu_io_register_block
  import ccio_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_open_bus,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_ram_request,
  output logic [16:0] out_ram_address,
  output logic [7:0]  out_ram_data,
  output logic        out_dma_start,
  output logic        out_counter_latch
);

  ccio_cmd_t cmd;
  ccio_sts_t sts;

  ccio_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ccio_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .opcode(in_opcode), .address(in_address), .write_data(in_write_data),
    .open_bus(in_open_bus), .read_data(out_read_data), .ram_request(out_ram_request),
    .ram_address(out_ram_address), .ram_data(out_ram_data),
    .dma_start(out_dma_start), .counter_latch(out_counter_latch)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input accepted while result pending");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |=> out_valid) else $error("divide done without result");
  a_req_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ram_request != 2'd3) else $error("bad ram request code");

endmodule

/* tb/console_cpu_io_register_block_tb.sv */
// testbench: cpu i/o register block, queued bus accesses checked against a behavioral predictor
module console_cpu_io_register_block_tb
  import ccio_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  obus;
  } access_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [1:0]  req;
    logic [16:0] raddr;
    logic [7:0]  rdat;
    logic        start;
    logic        latch;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [15:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_open_bus = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [1:0] out_ram_request;
  logic [16:0] out_ram_address;
  logic [7:0] out_ram_data;
  logic out_dma_start;
  logic out_counter_latch;

  console_cpu_io_register_block uut (.*);

  always #10 clk = ~clk;

  access_t pending_accesses[$];
  reply_t expected_replies[$];
  int error_count = 0;
  int accepted_count = 0;
  int reply_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;

  // predictor state
  logic [16:0] m_ptr;
  logic [7:0]  m_mul_l, m_mul_r, m_divisor, m_io, m_dma, m_hdma;
  logic [15:0] m_dividend, m_quo, m_pr;
  logic [8:0]  m_ht, m_vt;
  logic [7:0]  m_ctl[8], m_dst[8], m_sbank[8], m_ibank[8], m_lines[8], m_spare[8];
  logic [15:0] m_src[8], m_size[8], m_tbl[8];

  task automatic predict_reset();
    m_ptr = '0; m_mul_l = '0; m_mul_r = '0; m_divisor = '0; m_io = '0;
    m_dma = '0; m_hdma = '0; m_dividend = '0; m_quo = '0; m_pr = '0;
    m_ht = '0; m_vt = '0;
    for (int i = 0; i < 8; i++) begin
      m_ctl[i] = '0; m_dst[i] = '0; m_sbank[i] = '0; m_ibank[i] = '0;
      m_lines[i] = '0; m_spare[i] = '0; m_src[i] = '0; m_size[i] = '0; m_tbl[i] = '0;
    end
  endtask

  function automatic reply_t predict_access(access_t a);
    reply_t r;
    int c;
    logic hit;
    logic [3:0] reg_sel;
    r = '0;
    c = a.addr[6:4];
    hit = ((a.addr & 16'hff80) == CHAN_BASE) && (c < CHANNELS);
    reg_sel = a.addr[3:0];
    if (a.addr == PORT_DATA) begin
      r.req = a.wr ? REQ_WRITE : REQ_READ;
      r.raddr = m_ptr;
      r.rdat = a.wr ? a.wdata : 8'h00;
      m_ptr = (m_ptr + 17'd1) & PTR_MASK;
    end else if (!a.wr) begin
      r.rdata = a.obus;
      if (a.addr == A_IO_RD) r.rdata = m_io;
      else if (a.addr == A_QUO_LO) r.rdata = m_quo[7:0];
      else if (a.addr == A_QUO_HI) r.rdata = m_quo[15:8];
      else if (a.addr == A_PR_LO) r.rdata = m_pr[7:0];
      else if (a.addr == A_PR_HI) r.rdata = m_pr[15:8];
      else if (hit) begin
        case (reg_sel)
          4'h0: r.rdata = m_ctl[c];
          4'h1: r.rdata = m_dst[c];
          4'h2: r.rdata = m_src[c][7:0];
          4'h3: r.rdata = m_src[c][15:8];
          4'h4: r.rdata = m_sbank[c];
          4'h5: r.rdata = m_size[c][7:0];
          4'h6: r.rdata = m_size[c][15:8];
          4'h7: r.rdata = m_ibank[c];
          4'h8: r.rdata = m_tbl[c][7:0];
          4'h9: r.rdata = m_tbl[c][15:8];
          4'ha: r.rdata = m_lines[c];
          4'hb, 4'hf: r.rdata = m_spare[c];
          default: r.rdata = a.obus;
        endcase
      end
    end else begin
      case (a.addr)
        A_PTR_LO:  m_ptr[7:0] = a.wdata;
        A_PTR_MID: m_ptr[15:8] = a.wdata;
        A_PTR_HI:  m_ptr[16] = a.wdata[0];
        A_IO_PORT: begin
          r.latch = m_io[7] && !a.wdata[7];
          m_io = a.wdata;
        end
        A_MUL_L:   m_mul_l = a.wdata;
        A_MUL_R: begin
          m_mul_r = a.wdata;
          m_pr = m_mul_l * m_mul_r;
        end
        A_DVD_LO:  m_dividend[7:0] = a.wdata;
        A_DVD_HI:  m_dividend[15:8] = a.wdata;
        A_DIVISOR: begin
          m_divisor = a.wdata;
          if (m_divisor != 0) begin
            m_quo = m_dividend / m_divisor;
            m_pr = m_dividend % m_divisor;
          end else begin
            m_quo = 16'hffff;
            m_pr = m_dividend;
          end
        end
        A_HT_LO:   m_ht[7:0] = a.wdata;
        A_HT_HI:   m_ht[8] = a.wdata[0];
        A_VT_LO:   m_vt[7:0] = a.wdata;
        A_VT_HI:   m_vt[8] = a.wdata[0];
        A_DMA_EN: begin
          m_dma = a.wdata;
          r.start = a.wdata != 0;
        end
        A_HDMA_EN: m_hdma = a.wdata;
        default: begin
          if (hit) begin
            case (reg_sel)
              4'h0: m_ctl[c] = a.wdata;
              4'h1: m_dst[c] = a.wdata;
              4'h2: m_src[c][7:0] = a.wdata;
              4'h3: m_src[c][15:8] = a.wdata;
              4'h4: m_sbank[c] = a.wdata;
              4'h5: m_size[c][7:0] = a.wdata;
              4'h6: m_size[c][15:8] = a.wdata;
              4'h7: m_ibank[c] = a.wdata;
              4'h8: m_tbl[c][7:0] = a.wdata;
              4'h9: m_tbl[c][15:8] = a.wdata;
              4'ha: m_lines[c] = a.wdata;
              4'hb, 4'hf: m_spare[c] = a.wdata;
              default: ;
            endcase
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at word %0d: %s got %0h expected %0h", reply_count, field, got, want);
    error_count++;
  endtask

  task automatic queue_access(logic wr, logic [15:0] addr, logic [7:0] wdata);
    access_t a;
    a.wr = wr; a.addr = addr; a.wdata = wdata; a.obus = 8'($urandom);
    pending_accesses.push_back(a);
  endtask

  function automatic logic [15:0] pick_address();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: return PORT_DATA;
      2: return 16'h2181 + 16'($urandom_range(0, 2));
      3, 4: return 16'h4201 + 16'($urandom_range(0, 11));
      5: return 16'h4213 + 16'($urandom_range(0, 4));
      6, 7: return CHAN_BASE | 16'($urandom_range(0, 127));
      8: return 16'($urandom);
      default: return 16'h4200 + 16'($urandom_range(0, 255));
    endcase
  endfunction

  // driver: bursts of words with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          access_t a;
          a = pending_accesses.pop_front();
          in_valid <= 1'b1;
          in_opcode <= a.wr;
          in_address <= a.addr;
          in_write_data <= a.wdata;
          in_open_bus <= a.obus;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ((reply_count / 64) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: accept words, predict, and compare replies
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        access_t a;
        a.wr = in_opcode; a.addr = in_address; a.wdata = in_write_data; a.obus = in_open_bus;
        expected_replies.push_back(predict_access(a));
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        reply_t e;
        if (expected_replies.size() == 0) begin
          $display("unexpected reply word %0d", reply_count);
          error_count++;
        end else begin
          e = expected_replies.pop_front();
          if (e.req != REQ_READ && out_read_data !== e.rdata)
            report_mismatch("read_data", out_read_data, e.rdata);
          if (out_ram_request !== e.req) report_mismatch("ram_request", out_ram_request, e.req);
          if (out_ram_address !== e.raddr)
            report_mismatch("ram_address", out_ram_address, e.raddr);
          if (out_ram_data !== e.rdat) report_mismatch("ram_data", out_ram_data, e.rdat);
          if (out_dma_start !== e.start) report_mismatch("dma_start", out_dma_start, e.start);
          if (out_counter_latch !== e.latch)
            report_mismatch("counter_latch", out_counter_latch, e.latch);
        end
        reply_count++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    logic [7:0] d;
    predict_reset();
    // directed
    queue_access(1'b1, A_PTR_LO, 8'hff);
    queue_access(1'b1, A_PTR_MID, 8'hff);
    queue_access(1'b1, A_PTR_HI, 8'hff);
    queue_access(1'b1, PORT_DATA, 8'ha5);
    queue_access(1'b0, PORT_DATA, 8'h00);
    queue_access(1'b1, A_MUL_L, 8'hff);
    queue_access(1'b1, A_MUL_R, 8'hff);
    queue_access(1'b0, A_PR_LO, 8'h00);
    queue_access(1'b0, A_PR_HI, 8'h00);
    queue_access(1'b1, A_DVD_LO, 8'hff);
    queue_access(1'b1, A_DVD_HI, 8'hff);
    queue_access(1'b1, A_DIVISOR, 8'h00);
    queue_access(1'b0, A_QUO_LO, 8'h00);
    queue_access(1'b0, A_PR_HI, 8'h00);
    queue_access(1'b1, A_DIVISOR, 8'h01);
    queue_access(1'b0, A_QUO_HI, 8'h00);
    queue_access(1'b1, A_IO_PORT, 8'h80);
    queue_access(1'b1, A_IO_PORT, 8'h00);
    queue_access(1'b0, A_IO_RD, 8'h00);
    queue_access(1'b1, A_DMA_EN, 8'h00);
    queue_access(1'b1, A_DMA_EN, 8'h81);
    queue_access(1'b1, 16'h437b, 8'h5a);
    queue_access(1'b0, 16'h437f, 8'h00);
    queue_access(1'b0, 16'h437c, 8'h00);
    queue_access(1'b0, 16'hffff, 8'h00);
    // random: mostly mapped addresses, some noise
    for (n = 0; n < 900; n++) begin
      d = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff)
                                      : 8'($urandom);
      queue_access(1'($urandom), pick_address(), d);
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_accesses.size() > 0 || in_valid || expected_replies.size() > 0) begin
      @(posedge clk);
      if (idle_cycles > 2000) begin
        $display("watchdog: no progress");
        $display("Simulation FAILED");
        $finish;
      end
    end
    repeat (40) @(posedge clk);
    $display("covered %0d bus accesses: port data, pointer, math, timers, dma and channels",
             accepted_count);
    $display("%0d replies checked, %0d mismatches", reply_count, error_count);
    if (error_count == 0 && expected_replies.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
